FILE: design/bbti_pkg.sv
package bbti_pkg;

    // Filter store geometry
    localparam int FILTER_WORDS          = 65536;
    localparam int ADDR_W                = $clog2(FILTER_WORDS);
    localparam int MAX_BLOCKS_PER_REGION = 64;
    localparam int MAX_PROBES            = 16;

    // Field and register widths
    localparam int REGION_W     = 16;
    localparam int BLK_W        = 7;
    localparam int PROBE_W      = 5;
    localparam int REGION_CNT_W = 17;
    localparam int CNT_W        = 48;
    localparam int WORD_W       = 64;
    localparam int TAIL_W       = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int DIV_W        = 32;
    localparam int ADDR_FULL_W  = (REGION_W + BLK_W > ADDR_W) ?
                                  REGION_W + BLK_W + 1 : ADDR_W + 1;

    // Hash constants
    localparam logic [WORD_W-1:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
    localparam logic [WORD_W-1:0] MIX_C2 = 64'h94d049bb133111eb;
    localparam logic [WORD_W-1:0] GOLDEN = 64'h9e3779b97f4a7c15;
    localparam int SHIFT_A    = 30;
    localparam int SHIFT_B    = 27;
    localparam int SHIFT_C    = 31;
    localparam int PROBE_BITS = 6;
    localparam int REMIX_AT   = 5;
    localparam int LAST_CHUNK = 3;
    localparam int REMIX_ROUND = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FILTER_ENABLED    = 3'd0,
        CFG_HASH_SEED         = 3'd1,
        CFG_PROBE_COUNT       = 3'd2,
        CFG_BLOCKS_PER_REGION = 3'd3,
        CFG_REGION_COUNT      = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        STATUS_INSERTED     = 2'd0,
        STATUS_DUPLICATE    = 2'd1,
        STATUS_BYPASSED     = 2'd2,
        STATUS_OUT_OF_RANGE = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_M1_GO,
        ST_M1_WAIT,
        ST_M2_GO,
        ST_M2_WAIT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_READ,
        ST_CHECK,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] p;
    } mul_rsp_t;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] wdata;
    } store_req_t;

endpackage

FILE: design/bbti_mul64.sv
module bbti_mul64
    import bbti_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    typedef enum logic [1:0] {
        MS_LL = 2'd0,
        MS_LH = 2'd1,
        MS_HL = 2'd2
    } mul_step_t;

    localparam int HALF_W = WORD_W / 2;

    logic              busy_reg;
    logic              done_reg;
    mul_step_t         step_reg;
    logic [WORD_W-1:0] a_reg;
    logic [WORD_W-1:0] b_reg;
    logic [WORD_W-1:0] acc_reg;
    logic [WORD_W-1:0] acc_next;
    logic [HALF_W-1:0] opx;
    logic [HALF_W-1:0] opy;
    logic [WORD_W-1:0] prod;

    // Select the partial product for this step; the high-by-high term never
    // reaches the low 64 bits
    always_comb begin
        unique case (step_reg)
            MS_LL: begin
                opx = a_reg[HALF_W-1:0];
                opy = b_reg[HALF_W-1:0];
            end
            MS_LH: begin
                opx = a_reg[HALF_W-1:0];
                opy = b_reg[WORD_W-1:HALF_W];
            end
            MS_HL: begin
                opx = a_reg[WORD_W-1:HALF_W];
                opy = b_reg[HALF_W-1:0];
            end
            default: begin
                opx = '0;
                opy = '0;
            end
        endcase
    end

    assign prod = WORD_W'(opx) * WORD_W'(opy);

    // Accumulate cross terms into the upper half
    always_comb begin
        if (step_reg == MS_LL) begin
            acc_next = prod;
        end else begin
            acc_next = {acc_reg[WORD_W-1:HALF_W] + prod[HALF_W-1:0],
                        acc_reg[HALF_W-1:0]};
        end
    end

    // Sequence the three steps
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= MS_LL;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                step_reg <= MS_LL;
            end else if (busy_reg) begin
                unique case (step_reg)
                    MS_LL: step_reg <= MS_LH;
                    MS_LH: step_reg <= MS_HL;
                    default: begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                        step_reg <= MS_LL;
                    end
                endcase
            end
        end
    end

    // Hold operands and the running product
    always_ff @(posedge aclk) begin
        if (req.start) begin
            a_reg <= req.a;
            b_reg <= req.b;
        end
        if (busy_reg && !req.start) begin
            acc_reg <= acc_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.p    = acc_reg;

endmodule

FILE: design/bbti_rem.sv
module bbti_rem
    import bbti_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [BLK_W-1:0] divisor,
    output logic             done,
    output logic [BLK_W-1:0] remainder
);

    localparam int CNT_BITS = $clog2(DIV_W);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [DIV_W-1:0]    dvd_reg;
    logic [BLK_W-1:0]    dvs_reg;
    logic [BLK_W-1:0]    rem_reg;
    logic [BLK_W:0]      trial;
    logic [BLK_W-1:0]    rem_next;

    // Shift in one dividend bit and subtract when it fits
    assign trial = {rem_reg, dvd_reg[DIV_W-1]};

    always_comb begin
        if (trial >= {1'b0, dvs_reg}) begin
            rem_next = BLK_W'(trial - {1'b0, dvs_reg});
        end else begin
            rem_next = BLK_W'(trial);
        end
    end

    // Count the bit steps
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Hold the dividend shifter and the partial remainder
    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[DIV_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

FILE: design/bbti_store.sv
module bbti_store
    import bbti_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  store_req_t        req,
    output logic [WORD_W-1:0] rdata,
    output logic              clear_busy
);

    logic [WORD_W-1:0] mem [FILTER_WORDS];
    logic              clr_busy_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [WORD_W-1:0] rdata_reg;

    // Sweep the store to zero after reset, one word a cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_W'(FILTER_WORDS - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // Write port: clearing sweep or update
    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (req.wr_en) begin
            mem[req.addr] <= req.wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata      = rdata_reg;
    assign clear_busy = clr_busy_reg;

endmodule

FILE: design/blocked_bloom_test_and_insert.sv
// Blocked Bloom filter, test and insert. Each beat on the s_ channel carries a
// 26-byte record and a region number; one beat on the m_ channel answers it,
// in order. The block works on one item at a time and drops s_ready meanwhile.
// A checked item runs four hash rounds and the remainder step, then, when
// probe_count is above five, the re-mix (one more hash round), then a store
// read and check; an out-of-range item ends after the remainder step and a
// bypassed item goes straight to its result. The work is done by the single
// shared 32x32 multiplier, which builds each 64-bit product in three steps,
// and by the bit-serial remainder unit that picks the word within the region.
// After reset the 65536-word store is cleared, during which no item is
// accepted; configuration writes are taken at any time, one per cycle, and
// must only be made while the block is idle.
module blocked_bloom_test_and_insert
    import bbti_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [WORD_W-1:0]       cfg_data,

    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [REGION_W-1:0]     s_region,
    input  logic [WORD_W-1:0]       s_record_lo,
    input  logic [WORD_W-1:0]       s_record_mid,
    input  logic [WORD_W-1:0]       s_record_hi,
    input  logic [TAIL_W-1:0]       s_record_tail,

    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_seen,
    output logic [1:0]              m_status,
    output logic [CNT_W-1:0]        m_query_total,
    output logic [CNT_W-1:0]        m_duplicate_total
);

    state_t state_reg;
    state_t state_next;

    // Configuration registers
    logic                    enable_reg;
    logic [WORD_W-1:0]       seed_reg;
    logic [PROBE_W-1:0]      probes_reg;
    logic [BLK_W-1:0]        blocks_reg;
    logic [REGION_CNT_W-1:0] regions_reg;

    // Item context
    logic [REGION_W-1:0]     region_reg;
    logic [WORD_W-1:0]       rec_mid_reg;
    logic [WORD_W-1:0]       rec_hi_reg;
    logic [TAIL_W-1:0]       tail_reg;
    logic [PROBE_W-1:0]      nprobe_reg;
    logic [BLK_W-1:0]        nblk_reg;
    logic [WORD_W-1:0]       v_reg;
    logic [WORD_W-1:0]       hv_reg;
    logic [WORD_W-1:0]       rv_reg;
    logic [2:0]              round_reg;
    logic [ADDR_W-1:0]       addr_reg;
    logic                    seen_res_reg;
    status_t                 status_res_reg;
    logic [CNT_W-1:0]        query_cnt_reg;
    logic [CNT_W-1:0]        dup_cnt_reg;

    // Output register
    logic                    m_valid_reg;
    logic                    m_seen_reg;
    status_t                 m_status_reg;
    logic [CNT_W-1:0]        m_query_reg;
    logic [CNT_W-1:0]        m_dup_reg;

    // Shared units
    mul_req_t                mul_req;
    mul_rsp_t                mul_rsp;
    logic                    div_start;
    logic                    div_done;
    logic [BLK_W-1:0]        div_rem;
    store_req_t              st_req;
    logic [WORD_W-1:0]       st_rdata;
    logic                    clear_busy;

    logic                    s_beat;
    logic                    out_free;
    logic [PROBE_W-1:0]      nprobe_clamp;
    logic [BLK_W-1:0]        nblk_clamp;
    logic [WORD_W-1:0]       fin_val;
    logic [WORD_W-1:0]       next_chunk;
    logic [ADDR_FULL_W-1:0]  addr_full;
    logic                    out_of_range;
    logic [WORD_W-1:0]       probe_src;
    logic [WORD_W-1:0]       mask;
    logic                    all_set;

    bbti_mul64 u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    bbti_rem u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (hv_reg[WORD_W-1:DIV_W]),
        .divisor   (nblk_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    bbti_store u_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req        (st_req),
        .rdata      (st_rdata),
        .clear_busy (clear_busy)
    );

    assign cfg_ready = 1'b1;
    assign s_beat    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    // Clamp probe and block counts into their legal ranges
    always_comb begin
        if (probes_reg == '0) begin
            nprobe_clamp = PROBE_W'(1);
        end else if (probes_reg > PROBE_W'(MAX_PROBES)) begin
            nprobe_clamp = PROBE_W'(MAX_PROBES);
        end else begin
            nprobe_clamp = probes_reg;
        end
        if (blocks_reg == '0) begin
            nblk_clamp = BLK_W'(1);
        end else if (blocks_reg > BLK_W'(MAX_BLOCKS_PER_REGION)) begin
            nblk_clamp = BLK_W'(MAX_BLOCKS_PER_REGION);
        end else begin
            nblk_clamp = blocks_reg;
        end
    end

    // Finish a mixing round and pick the next record chunk
    assign fin_val = mul_rsp.p ^ (mul_rsp.p >> SHIFT_C);

    always_comb begin
        unique case (round_reg)
            3'd0:    next_chunk = rec_mid_reg;
            3'd1:    next_chunk = rec_hi_reg;
            default: next_chunk = {{(WORD_W - TAIL_W){1'b0}}, tail_reg};
        endcase
    end

    // Word address within the store and range check
    assign addr_full = ADDR_FULL_W'(region_reg) * ADDR_FULL_W'(nblk_reg)
                     + ADDR_FULL_W'(div_rem);
    assign out_of_range = ({1'b0, region_reg} >= regions_reg)
                       || (addr_full >= ADDR_FULL_W'(FILTER_WORDS));

    // Build the probe mask; probes past the fifth draw from the re-mixed hash
    always_comb begin
        mask      = '0;
        probe_src = '0;
        for (int j = 0; j < MAX_PROBES; j++) begin
            if (j < REMIX_AT) begin
                probe_src = hv_reg >> (PROBE_BITS * j);
            end else begin
                probe_src = rv_reg >> (PROBE_BITS * (j - REMIX_AT));
            end
            if (PROBE_W'(j) < nprobe_reg) begin
                mask = mask | (WORD_W'(1) << probe_src[PROBE_BITS-1:0]);
            end
        end
    end

    assign all_set = ((st_rdata & mask) == mask);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (!clear_busy) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_beat) begin
                    state_next = enable_reg ? ST_M1_GO : ST_FINISH;
                end
            end
            ST_M1_GO:   state_next = ST_M1_WAIT;
            ST_M1_WAIT: begin
                if (mul_rsp.done) begin
                    state_next = ST_M2_GO;
                end
            end
            ST_M2_GO:   state_next = ST_M2_WAIT;
            ST_M2_WAIT: begin
                if (mul_rsp.done) begin
                    if (round_reg == 3'(LAST_CHUNK)) begin
                        state_next = ST_DIV_GO;
                    end else if (round_reg == 3'(REMIX_ROUND)) begin
                        state_next = ST_READ;
                    end else begin
                        state_next = ST_M1_GO;
                    end
                end
            end
            ST_DIV_GO:  state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_done) begin
                    if (out_of_range) begin
                        state_next = ST_FINISH;
                    end else if (nprobe_reg > PROBE_W'(REMIX_AT)) begin
                        state_next = ST_M1_GO;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:    state_next = ST_CHECK;
            ST_CHECK:   state_next = ST_FINISH;
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_CLEAR;
        endcase
    end

    // Unit controls
    always_comb begin
        s_ready       = 1'b0;
        mul_req.start = 1'b0;
        mul_req.a     = v_reg ^ (v_reg >> SHIFT_A);
        mul_req.b     = MIX_C1;
        div_start     = 1'b0;
        st_req.rd_en  = 1'b0;
        st_req.wr_en  = 1'b0;
        st_req.addr   = addr_reg;
        st_req.wdata  = st_rdata | mask;
        unique case (state_reg)
            ST_IDLE:   s_ready = 1'b1;
            ST_M1_GO:  mul_req.start = 1'b1;
            ST_M2_GO: begin
                mul_req.start = 1'b1;
                mul_req.a     = v_reg ^ (v_reg >> SHIFT_B);
                mul_req.b     = MIX_C2;
            end
            ST_DIV_GO: div_start = 1'b1;
            ST_READ:   st_req.rd_en = 1'b1;
            ST_CHECK:  st_req.wr_en = !all_set;
            default: begin
            end
        endcase
    end

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg  <= 1'b0;
            seed_reg    <= '0;
            probes_reg  <= PROBE_W'(1);
            blocks_reg  <= BLK_W'(1);
            regions_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_FILTER_ENABLED:    enable_reg  <= cfg_data[0];
                CFG_HASH_SEED:         seed_reg    <= cfg_data;
                CFG_PROBE_COUNT:       probes_reg  <= cfg_data[PROBE_W-1:0];
                CFG_BLOCKS_PER_REGION: blocks_reg  <= cfg_data[BLK_W-1:0];
                CFG_REGION_COUNT:      regions_reg <= cfg_data[REGION_CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Control state, counters and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            query_cnt_reg <= '0;
            dup_cnt_reg   <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (s_beat && enable_reg) begin
                query_cnt_reg <= query_cnt_reg + 1'b1;
            end
            if (state_reg == ST_CHECK && all_set) begin
                dup_cnt_reg <= dup_cnt_reg + 1'b1;
            end
            if (state_reg == ST_FINISH && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Item datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (s_beat) begin
                    region_reg     <= s_region;
                    rec_mid_reg    <= s_record_mid;
                    rec_hi_reg     <= s_record_hi;
                    tail_reg       <= s_record_tail;
                    nprobe_reg     <= nprobe_clamp;
                    nblk_reg       <= nblk_clamp;
                    v_reg          <= (seed_reg + GOLDEN) ^ s_record_lo;
                    round_reg      <= '0;
                    seen_res_reg   <= 1'b0;
                    status_res_reg <= STATUS_BYPASSED;
                end
            end
            ST_M1_WAIT: begin
                if (mul_rsp.done) begin
                    v_reg <= mul_rsp.p;
                end
            end
            ST_M2_WAIT: begin
                if (mul_rsp.done) begin
                    if (round_reg == 3'(LAST_CHUNK)) begin
                        hv_reg <= fin_val;
                    end else if (round_reg == 3'(REMIX_ROUND)) begin
                        rv_reg <= fin_val;
                    end else begin
                        v_reg     <= fin_val ^ next_chunk;
                        round_reg <= round_reg + 1'b1;
                    end
                end
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    addr_reg       <= addr_full[ADDR_W-1:0];
                    v_reg          <= hv_reg;
                    round_reg      <= 3'(REMIX_ROUND);
                    status_res_reg <= STATUS_OUT_OF_RANGE;
                end
            end
            ST_CHECK: begin
                seen_res_reg   <= all_set;
                status_res_reg <= all_set ? STATUS_DUPLICATE : STATUS_INSERTED;
            end
            default: begin
            end
        endcase
    end

    // Load the result beat once the output register is free
    always_ff @(posedge aclk) begin
        if (state_reg == ST_FINISH && out_free) begin
            m_seen_reg   <= seen_res_reg;
            m_status_reg <= status_res_reg;
            m_query_reg  <= query_cnt_reg;
            m_dup_reg    <= dup_cnt_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_seen            = m_seen_reg;
    assign m_status          = m_status_reg;
    assign m_query_total     = m_query_reg;
    assign m_duplicate_total = m_dup_reg;

    // No item enters while the store is being cleared
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !clear_busy)
        else $error("item accepted during clearing sweep");

    // Multiplier results arrive only where the sequencer waits for them
    a_mul_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_rsp.done |-> (state_reg == ST_M1_WAIT || state_reg == ST_M2_WAIT))
        else $error("multiplier result outside a wait state");

    // Store writes only at the check step and never to a word already holding the mask
    a_write_only_on_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        st_req.wr_en |-> (state_reg == ST_CHECK && !all_set))
        else $error("store written outside an insert");

    // Duplicate count moves only after a check that found every bit set
    a_dup_count_source: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && dup_cnt_reg != $past(dup_cnt_reg))
        |-> ($past(state_reg) == ST_CHECK && $past(all_set)))
        else $error("duplicate count changed without a duplicate");

    // A result beat is loaded only from the finish step
    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_FINISH)
        else $error("result beat raised outside the finish step");

endmodule

FILE: test/blocked_bloom_test_and_insert_tb.sv
`timescale 1ns / 1ps

module blocked_bloom_test_and_insert_tb;
    import bbti_pkg::*;

    localparam int RUN_LIMIT   = 2_000_000;
    localparam int HOLD_AFTER  = 400;
    localparam int HOLD_CYCLES = 700;
    localparam int RANDOM_SETTINGS = 6;
    localparam int RECORDS_PER_SETTING = 215;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 3'd5;

    localparam logic [63:0] MULT_ONE     = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MULT_TWO     = 64'h94d049bb133111eb;
    localparam logic [63:0] GOLDEN_RATIO = 64'h9e3779b97f4a7c15;

    typedef struct {
        logic [REGION_W-1:0] region;
        logic [WORD_W-1:0]   lo;
        logic [WORD_W-1:0]   mid;
        logic [WORD_W-1:0]   hi;
        logic [TAIL_W-1:0]   tail;
    } record_t;

    typedef struct {
        logic             seen;
        status_t          status;
        logic [CNT_W-1:0] query_total;
        logic [CNT_W-1:0] duplicate_total;
    } verdict_t;

    typedef struct {
        logic [CFG_IDX_W-1:0] index;
        logic [WORD_W-1:0]    data;
    } reg_write_t;

    typedef enum {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PERIODIC} ready_style_t;

    logic                 aclk;
    logic                 aresetn = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0]    cfg_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [REGION_W-1:0]  s_region = '0;
    logic [WORD_W-1:0]    s_record_lo = '0;
    logic [WORD_W-1:0]    s_record_mid = '0;
    logic [WORD_W-1:0]    s_record_hi = '0;
    logic [TAIL_W-1:0]    s_record_tail = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_seen;
    logic [1:0]           m_status;
    logic [CNT_W-1:0]     m_query_total;
    logic [CNT_W-1:0]     m_duplicate_total;

    // filter image and register shadows, kept in step with the block
    logic [WORD_W-1:0]       word_image [FILTER_WORDS];
    logic                    en_shadow = 1'b0;
    logic [WORD_W-1:0]       seed_shadow = '0;
    logic [PROBE_W-1:0]      probes_shadow = 5'd1;
    logic [BLK_W-1:0]        blocks_shadow = 7'd1;
    logic [REGION_CNT_W-1:0] regions_shadow = '0;
    logic [CNT_W-1:0]        checked_count = '0;
    logic [CNT_W-1:0]        dup_count = '0;

    record_t    pending_records[$];
    record_t    recent_records[$];
    verdict_t   expected_verdicts[$];
    reg_write_t reg_writes[$];

    record_t      offered;
    reg_write_t   next_write;
    verdict_t     want;
    int           burst_left = 0;
    int           gap_left = 0;
    int           hold_left = 0;
    int           ready_tick = 0;
    ready_style_t ready_style = READY_ALWAYS;
    int           cycle_count = 0;
    int           records_queued = 0;
    int           records_sent = 0;
    int           results_taken = 0;
    int           fail_count = 0;
    int           settings_used = 0;
    int           status_hits [4] = '{0, 0, 0, 0};

    blocked_bloom_test_and_insert dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_region          (s_region),
        .s_record_lo       (s_record_lo),
        .s_record_mid      (s_record_mid),
        .s_record_hi       (s_record_hi),
        .s_record_tail     (s_record_tail),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_seen            (m_seen),
        .m_status          (m_status),
        .m_query_total     (m_query_total),
        .m_duplicate_total (m_duplicate_total)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // one finalizer round of the record hash
    function automatic logic [63:0] avalanche(logic [63:0] v);
        v = (v ^ (v >> 30)) * MULT_ONE;
        v = (v ^ (v >> 27)) * MULT_TWO;
        return v ^ (v >> 31);
    endfunction

    // test a record against the filter image and insert it when new
    function automatic verdict_t test_and_insert(record_t r);
        verdict_t    v;
        logic [63:0] digest;
        logic [63:0] src;
        logic [63:0] mask;
        logic [63:0] nprobe;
        logic [63:0] nblk;
        logic [63:0] addr;
        v.seen = 1'b0;
        if (!en_shadow) begin
            v.status = STATUS_BYPASSED;
        end else begin
            nprobe = (probes_shadow == 0) ? 64'd1 :
                     (probes_shadow > MAX_PROBES) ? 64'(MAX_PROBES) : 64'(probes_shadow);
            nblk = (blocks_shadow == 0) ? 64'd1 :
                   (blocks_shadow > MAX_BLOCKS_PER_REGION) ? 64'(MAX_BLOCKS_PER_REGION) :
                   64'(blocks_shadow);
            checked_count = checked_count + 1'b1;
            digest = seed_shadow + GOLDEN_RATIO;
            digest = avalanche(digest ^ r.lo);
            digest = avalanche(digest ^ r.mid);
            digest = avalanche(digest ^ r.hi);
            digest = avalanche(digest ^ {48'd0, r.tail});
            addr = {48'd0, r.region} * nblk + {32'd0, digest[63:32]} % nblk;
            if (r.region >= regions_shadow || addr >= 64'(FILTER_WORDS)) begin
                v.status = STATUS_OUT_OF_RANGE;
            end else begin
                mask = '0;
                src = digest;
                for (int j = 0; j < nprobe; j++) begin
                    // fresh bits for probes past the fifth
                    if (j == 5) src = avalanche(digest);
                    mask |= 64'd1 << src[5:0];
                    src = src >> 6;
                end
                if ((word_image[addr[ADDR_W-1:0]] & mask) == mask) begin
                    v.seen = 1'b1;
                    v.status = STATUS_DUPLICATE;
                    dup_count = dup_count + 1'b1;
                end else begin
                    word_image[addr[ADDR_W-1:0]] |= mask;
                    v.status = STATUS_INSERTED;
                end
            end
        end
        v.query_total = checked_count;
        v.duplicate_total = dup_count;
        return v;
    endfunction

    task automatic queue_record(record_t r);
        pending_records.insert(pending_records.size(), r);
        recent_records.insert(recent_records.size(), r);
        records_queued++;
        if (recent_records.size() > 64) void'(recent_records.pop_front());
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [WORD_W-1:0] data);
        reg_writes.insert(reg_writes.size(), reg_write_t'{index, data});
    endtask

    // wait until every queued register write has gone through
    task automatic settle_regs();
        do @(posedge aclk); while (reg_writes.size() != 0 || cfg_valid);
    endtask

    // wait until every queued record has been answered, then let the block idle
    task automatic drain();
        do @(posedge aclk);
        while (results_taken != records_queued);
        repeat (4) @(posedge aclk);
    endtask

    // register writes: shadow each beat the block takes
    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_valid <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_FILTER_ENABLED:    en_shadow = cfg_data[0];
                    CFG_HASH_SEED:         seed_shadow = cfg_data;
                    CFG_PROBE_COUNT:       probes_shadow = cfg_data[PROBE_W-1:0];
                    CFG_BLOCKS_PER_REGION: blocks_shadow = cfg_data[BLK_W-1:0];
                    CFG_REGION_COUNT:      regions_shadow = cfg_data[REGION_CNT_W-1:0];
                    default: ;
                endcase
            end
            if (!cfg_valid || cfg_ready) begin
                if (reg_writes.size() != 0) begin
                    next_write = reg_writes.pop_front();
                    cfg_valid <= 1'b1;
                    cfg_index <= next_write.index;
                    cfg_data <= next_write.data;
                end else begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    // record driver: bursts of beats separated by random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_verdicts.insert(expected_verdicts.size(), test_and_insert(offered));
                records_sent++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0 || pending_records.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    s_valid <= 1'b0;
                end else begin
                    offered = pending_records.pop_front();
                    s_valid <= 1'b1;
                    s_region <= offered.region;
                    s_record_lo <= offered.lo;
                    s_record_mid <= offered.mid;
                    s_record_hi <= offered.hi;
                    s_record_tail <= offered.tail;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 16);
                        case ($urandom_range(0, 19))
                            0, 1, 2, 3, 4: gap_left = 0;
                            5:             gap_left = $urandom_range(60, 150);
                            default:       gap_left = $urandom_range(1, 40);
                        endcase
                    end
                end
            end
        end
    end

    // result monitor: check each beat, stall on a shifting pattern
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_verdicts.size() == 0) begin
                    $error("result beat with no record outstanding");
                    fail_count++;
                end else begin
                    want = expected_verdicts.pop_front();
                    if (m_seen !== want.seen) begin
                        $error("seen: expected %0d, got %0d", want.seen, m_seen);
                        fail_count++;
                    end
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_status);
                        fail_count++;
                    end
                    if (m_query_total !== want.query_total) begin
                        $error("query_total: expected %0d, got %0d",
                               want.query_total, m_query_total);
                        fail_count++;
                    end
                    if (m_duplicate_total !== want.duplicate_total) begin
                        $error("duplicate_total: expected %0d, got %0d",
                               want.duplicate_total, m_duplicate_total);
                        fail_count++;
                    end
                end
                results_taken++;
                if (!$isunknown(m_status)) status_hits[m_status]++;
                // back-pressure once for a long stretch so the input stalls
                if (results_taken == HOLD_AFTER) hold_left = HOLD_CYCLES;
            end
            ready_tick++;
            if (ready_tick % 211 == 0) ready_style = ready_style_t'($urandom_range(0, 3));
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (ready_style)
                    READY_ALWAYS:  m_ready <= 1'b1;
                    READY_COIN:    m_ready <= 1'($urandom_range(0, 1));
                    READY_SPARSE:  m_ready <= ($urandom_range(0, 3) == 0);
                    default:       m_ready <= ((ready_tick % 7) < 3);
                endcase
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == RUN_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        logic [WORD_W-1:0]       junk;
        logic [REGION_CNT_W-1:0] rc;
        logic [PROBE_W-1:0]      pc;
        logic [BLK_W-1:0]        bc;
        logic [WORD_W-1:0]       seed;
        logic                    en;
        int                      lim;
        record_t                 r;

        foreach (word_image[i]) word_image[i] = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // reset state: filter disabled, every record bypasses
        queue_record(record_t'{16'd0, '0, '0, '0, 16'h0000});
        queue_record(record_t'{16'hffff, '1, '1, '1, 16'hffff});
        queue_record(record_t'{16'h1234, 64'h5555aaaa5555aaaa, 64'haaaa5555aaaa5555,
                               64'h00ff00ff00ff00ff, 16'h5aa5});
        drain();

        // enable with no valid regions; probe and block counts of zero
        write_reg(CFG_FILTER_ENABLED, '1);
        write_reg(CFG_HASH_SEED, '0);
        write_reg(CFG_PROBE_COUNT, 64'hffff_ffff_ffff_ffe0);
        write_reg(CFG_BLOCKS_PER_REGION, 64'hffff_ffff_ffff_ff80);
        write_reg(CFG_REGION_COUNT, 64'hffff_ffff_fffe_0000);
        settle_regs();
        settings_used++;
        queue_record(record_t'{16'd0, '0, '0, '0, 16'h0000});
        queue_record(record_t'{16'hffff, '1, '1, '1, 16'hffff});
        drain();

        // every region valid, oversized probe and block counts, all-ones seed
        write_reg(CFG_REGION_COUNT, 64'd65536);
        write_reg(CFG_BLOCKS_PER_REGION, 64'd127);
        write_reg(CFG_PROBE_COUNT, 64'd31);
        write_reg(CFG_HASH_SEED, '1);
        settle_regs();
        settings_used++;
        queue_record(record_t'{16'd0, 64'h0123456789abcdef, 64'hfedcba9876543210,
                               64'h0f1e2d3c4b5a6978, 16'h00ff});
        queue_record(record_t'{16'd0, 64'h0123456789abcdef, 64'hfedcba9876543210,
                               64'h0f1e2d3c4b5a6978, 16'h00ff});
        queue_record(record_t'{16'd1023, '1, '1, '1, 16'hffff});
        queue_record(record_t'{16'd1023, '1, '1, '1, 16'hffff});
        // word address runs past the store
        queue_record(record_t'{16'd1024, '0, '0, '0, 16'h0000});
        queue_record(record_t'{16'hffff, '0, '1, '0, 16'h8001});
        queue_record(record_t'{16'd0, '0, '0, '0, 16'hffff});
        queue_record(record_t'{16'd0, '1, '0, '1, 16'h0000});
        drain();

        // writes to unmapped indexes leave the registers alone
        write_reg(CFG_UNMAPPED_HI, '1);
        write_reg(CFG_UNMAPPED_LO, 64'h0123456789abcdef);
        settle_regs();
        queue_record(record_t'{16'd0, 64'h0123456789abcdef, 64'hfedcba9876543210,
                               64'h0f1e2d3c4b5a6978, 16'h00ff});
        drain();

        // one region of one word, six probes: crosses the re-mix point
        write_reg(CFG_PROBE_COUNT, 64'd6);
        write_reg(CFG_BLOCKS_PER_REGION, 64'd1);
        write_reg(CFG_REGION_COUNT, 64'd1);
        write_reg(CFG_HASH_SEED, {$urandom, $urandom});
        settle_regs();
        settings_used++;
        for (int i = 0; i < 5; i++)
            queue_record(record_t'{16'd0, {$urandom, $urandom}, {$urandom, $urandom},
                                   {$urandom, $urandom}, 16'($urandom)});
        queue_record(recent_records[recent_records.size() - 1]);
        queue_record(recent_records[recent_records.size() - 3]);
        queue_record(record_t'{16'd1, '0, '0, '0, 16'h0000});
        drain();

        // random settings, each followed by a stream of records
        for (int s = 0; s < RANDOM_SETTINGS; s++) begin
            junk = {$urandom, $urandom};
            en = ($urandom_range(0, 7) != 0);
            case ($urandom_range(0, 5))
                0:       pc = 5'd0;
                1:       pc = 5'd1;
                2:       pc = 5'd5;
                3:       pc = 5'd6;
                4:       pc = 5'd16;
                default: pc = 5'($urandom_range(0, 31));
            endcase
            case ($urandom_range(0, 5))
                0:       bc = 7'd0;
                1:       bc = 7'd1;
                2:       bc = 7'd64;
                3:       bc = 7'd127;
                default: bc = 7'($urandom_range(0, 127));
            endcase
            case ($urandom_range(0, 5))
                0:       rc = 17'($urandom_range(1, 8));
                1:       rc = 17'd1024;
                2:       rc = 17'd65536;
                3:       rc = 17'd131071;
                4:       rc = 17'($urandom_range(1, 4));
                default: rc = 17'($urandom_range(0, 131071));
            endcase
            case ($urandom_range(0, 3))
                0:       seed = '0;
                1:       seed = '1;
                default: seed = {$urandom, $urandom};
            endcase
            write_reg(CFG_FILTER_ENABLED, {junk[63:1], en});
            write_reg(CFG_HASH_SEED, seed);
            write_reg(CFG_PROBE_COUNT, {junk[63:PROBE_W], pc});
            write_reg(CFG_BLOCKS_PER_REGION, {junk[63:BLK_W], bc});
            write_reg(CFG_REGION_COUNT, {junk[63:REGION_CNT_W], rc});
            settle_regs();
            settings_used++;

            lim = (rc == 0) ? 8 : ((rc < 8) ? int'(rc) : 8);
            for (int i = 0; i < RECORDS_PER_SETTING; i++) begin
                // repeats drive the duplicate path, fresh records fill words
                if (recent_records.size() != 0 && $urandom_range(0, 99) < 35) begin
                    r = recent_records[$urandom_range(0, recent_records.size() - 1)];
                end else begin
                    r.lo = {$urandom, $urandom};
                    r.mid = {$urandom, $urandom};
                    r.hi = {$urandom, $urandom};
                    r.tail = 16'($urandom);
                    case ($urandom_range(0, 19))
                        0, 1, 2:    r.region = 16'($urandom);
                        3:          r.region = ($urandom_range(0, 1) != 0) ? 16'hffff : 16'd0;
                        4, 5:       r.region = (rc == 0) ? 16'd0 : 16'(rc - 1);
                        6:          r.region = (rc > 17'hffff) ? 16'hffff : 16'(rc);
                        default:    r.region = 16'($urandom_range(0, lim - 1));
                    endcase
                end
                queue_record(r);
            end
            drain();
        end

        repeat (100) @(posedge aclk);
        $display("Ran %0d records under %0d register settings, %0d results checked",
                 records_sent, settings_used, results_taken);
        $display("Outcomes: %0d inserted, %0d duplicate, %0d bypassed, %0d out of range",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3]);
        if (fail_count == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: files.f
design/bbti_pkg.sv
design/bbti_mul64.sv
design/bbti_rem.sv
design/bbti_store.sv
design/blocked_bloom_test_and_insert.sv
test/blocked_bloom_test_and_insert_tb.sv
